[hdl/ssil_pkg.sv]
// Shared types, codes and helpers for the sorted insertion task list.
`default_nettype none
package ssil_pkg;

    // Field widths fixed by the word format.
    localparam int TAG_W     = 16;
    localparam int RANK_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int DEPTH_DEF = 16;

    // Operation codes carried by the func field.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DUMP   = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_VALID = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // One stored entry.
    typedef struct packed {
        logic [TAG_W-1:0]         tag;
        logic signed [RANK_W-1:0] rank;
    } t_entry;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_DUMP_RD,
        S_DUMP_OUT
    } t_state;

    // True when a stored rank must move behind the new one (strictly higher).
    function automatic logic rank_after(input logic signed [RANK_W-1:0] stored,
                                        input logic signed [RANK_W-1:0] incoming);
        return stored > incoming;
    endfunction

endpackage
`default_nettype wire

[hdl/stable_sorted_insert_list_top.sv]
// Top level of the sorted insertion task list with its sequencer.
//
//  channel | direction | handshake          | fields
//  --------+-----------+--------------------+----------------------------------------
//  request | in        | i_valid / o_stall  | i_func, i_task_tag, i_task_rank
//  result  | out       | o_valid / i_stall  | o_out_tag, o_out_rank, o_status, o_last
//
// An insert walks down from the top of the list, reading the entry below the hole; each
// entry of higher rank is moved up one place through the store's read and write ports,
// and the new entry is written into the hole where the walk stops.
// A dump reads the stored entries in order from the bottom, waiting while the result side stalls.
// A full insert or an empty dump gives its single word in the cycle after acceptance.
// Reset clears the state, the entry count and the result valid flag; stored entries are unused until rewritten.
// The block takes no new request while a request is in work or a word waits stalled.
`default_nettype none
module stable_sorted_insert_list_top #(
    parameter int DEPTH = ssil_pkg::DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic                               i_func,
    input  wire logic [ssil_pkg::TAG_W-1:0]         i_task_tag,
    input  wire logic signed [ssil_pkg::RANK_W-1:0] i_task_rank,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [ssil_pkg::TAG_W-1:0]              o_out_tag,
    output logic signed [ssil_pkg::RANK_W-1:0]      o_out_rank,
    output logic [ssil_pkg::STATUS_W-1:0]           o_status,
    output logic                                    o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ssil_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    ssil_pkg::t_entry r_new, n_new;

    logic                 r_out_valid, n_out_valid;
    ssil_pkg::t_entry     r_out_entry, n_out_entry;
    ssil_pkg::t_status    r_out_status, n_out_status;
    logic                 r_out_last, n_out_last;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    ssil_pkg::t_entry wr_data;
    logic [AW-1:0]    rd_addr;
    ssil_pkg::t_entry rd_data;

    logic             out_busy;
    logic             out_free;
    logic             in_accept;
    logic [CW-1:0]    idx_dec;

    ssil_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Handshake terms.
    assign out_busy  = r_out_valid && i_stall;
    assign out_free  = !out_busy;
    assign o_stall   = (r_state != ssil_pkg::S_IDLE) || out_busy;
    assign in_accept = i_valid && !o_stall;
    assign idx_dec   = r_idx - CW'(1);

    // The insert walk reads the entry below the hole; a dump reads at the index.
    always_comb begin
        if (r_state == ssil_pkg::S_INS_RD || r_state == ssil_pkg::S_INS_CMP) begin
            rd_addr = idx_dec[AW-1:0];
        end else begin
            rd_addr = r_idx[AW-1:0];
        end
    end

    // Sequencer: next state, memory writes and the result word.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_new        = r_new;
        n_out_valid  = r_out_valid && i_stall;
        n_out_entry  = r_out_entry;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        wr_en        = 1'b0;
        wr_addr      = r_idx[AW-1:0];
        wr_data      = r_new;

        case (r_state)
            ssil_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_func == ssil_pkg::FUNC_INSERT) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_out_valid       = 1'b1;
                            n_out_entry.tag   = '0;
                            n_out_entry.rank  = '0;
                            n_out_status      = ssil_pkg::ST_FULL;
                            n_out_last        = 1'b1;
                        end else begin
                            n_new.tag  = i_task_tag;
                            n_new.rank = i_task_rank;
                            n_idx      = r_count;
                            n_state    = ssil_pkg::S_INS_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_out_valid       = 1'b1;
                            n_out_entry.tag   = '0;
                            n_out_entry.rank  = '0;
                            n_out_status      = ssil_pkg::ST_EMPTY;
                            n_out_last        = 1'b1;
                        end else begin
                            n_idx   = '0;
                            n_state = ssil_pkg::S_DUMP_RD;
                        end
                    end
                end
            end

            ssil_pkg::S_INS_RD: begin
                // At the bottom the hole is the place of the new entry.
                if (r_idx == '0) begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = ssil_pkg::S_IDLE;
                end else begin
                    n_state = ssil_pkg::S_INS_CMP;
                end
            end

            ssil_pkg::S_INS_CMP: begin
                // A strictly higher rank moves up; an equal or lower one stays put.
                wr_en = 1'b1;
                if (ssil_pkg::rank_after(rd_data.rank, r_new.rank)) begin
                    wr_data = rd_data;
                    n_idx   = idx_dec;
                    n_state = ssil_pkg::S_INS_RD;
                end else begin
                    n_count = r_count + CW'(1);
                    n_state = ssil_pkg::S_IDLE;
                end
            end

            ssil_pkg::S_DUMP_RD: begin
                n_state = ssil_pkg::S_DUMP_OUT;
            end

            ssil_pkg::S_DUMP_OUT: begin
                // Hand the read entry over once the result register is free.
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_entry  = rd_data;
                    n_out_status = ssil_pkg::ST_VALID;
                    n_out_last   = ((r_idx + CW'(1)) == r_count);
                    if ((r_idx + CW'(1)) == r_count) begin
                        n_state = ssil_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = ssil_pkg::S_DUMP_RD;
                    end
                end
            end

            default: begin
                n_state = ssil_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssil_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_new        <= n_new;
        r_out_entry  <= n_out_entry;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_valid    = r_out_valid;
    assign o_out_tag  = r_out_entry.tag;
    assign o_out_rank = r_out_entry.rank;
    assign o_status   = r_out_status;
    assign o_last     = r_out_last;

endmodule
`default_nettype wire

[hdl/ssil_store.sv]
// Entry memory: one write port and one registered read port.
`default_nettype none
module ssil_store #(
    parameter int DEPTH = ssil_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  wire ssil_pkg::t_entry i_wr_data,
    input  wire logic [AW-1:0]   i_rd_addr,
    output ssil_pkg::t_entry     o_rd_data
);

    ssil_pkg::t_entry r_mem [DEPTH];
    ssil_pkg::t_entry r_rd_data;

    // Write and registered read; the contents need no reset.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire
